// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the tilt filter RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/tcf_pkg.sv -----
// Package for the tilt complementary filter: widths, constants, sequencer states,
// arctangent table and saturation helper. Depends on nothing.
package tcf_pkg;

    localparam int DATA_W           = 36;
    localparam int ANGLE_W          = 32;
    localparam int SAMPLE_W         = 16;
    localparam int FRAC_W           = 16;
    localparam int MUL_B_W          = 18;
    localparam int PROD_W           = DATA_W + MUL_B_W;
    localparam int ATAN_LEN         = 24;
    localparam int STEP_W           = 5;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int WEIGHT_W         = 17;
    localparam int SCALE_W          = 16;
    localparam int CFG_IDX_W        = 4;
    localparam int ITEM_W           = 6 * SAMPLE_W;
    localparam int RESULT_W         = 3 * ANGLE_W;

    localparam logic [MUL_B_W-1:0]   INV_GAIN     = 18'd39797;
    localparam logic [WEIGHT_W-1:0]  ONE_Q16      = 17'd65536;
    localparam logic [WEIGHT_W-1:0]  BLEND_RESET  = 17'd52429;
    localparam logic [SCALE_W-1:0]   SCALE_RESET  = 16'd1638;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_SCALE   = 4'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YAW_MUL,
        ST_YAW_ACC,
        ST_MAG,
        ST_MAG_WAIT,
        ST_GAIN,
        ST_ANG_WAIT,
        ST_RATE,
        ST_BLEND_W,
        ST_BLEND_A,
        ST_BLEND_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    localparam logic signed [ANGLE_W-1:0] ATAN_DEG [ATAN_LEN] = '{
        32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
        32'sd234379,  32'sd117304,  32'sd58666,  32'sd29335,
        32'sd14668,   32'sd7334,    32'sd3667,   32'sd1833,
        32'sd917,     32'sd458,     32'sd229,    32'sd115,
        32'sd57,      32'sd29,      32'sd14,     32'sd7,
        32'sd4,       32'sd2,       32'sd1,      32'sd0
    };

    function automatic logic signed [ANGLE_W-1:0] atan_deg(input logic [STEP_W-1:0] idx);
        logic signed [ANGLE_W-1:0] r;
        r = '0;
        for (int i = 0; i < ATAN_LEN; i++)
        begin
            if (idx == STEP_W'(i))
            begin
                r = ATAN_DEG[i];
            end
        end
        return r;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [ANGLE_W-1:0] r;
        if ((&v[PROD_W-1:ANGLE_W-1]) || (~|v[PROD_W-1:ANGLE_W-1]))
        begin
            r = v[ANGLE_W-1:0];
        end
        else if (v[PROD_W-1])
        begin
            r = {1'b1, {(ANGLE_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(ANGLE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/tcf_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on tcf_pkg for operand and product widths.
module tcf_mul
(
    input  logic                                  clk,
    input  logic signed [tcf_pkg::DATA_W-1:0]     a,
    input  logic signed [tcf_pkg::MUL_B_W-1:0]    b,
    output logic signed [tcf_pkg::PROD_W-1:0]     p
);
    import tcf_pkg::*;

    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    assign p_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ----- rtl/core/tcf_cordic.sv -----
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle in Q16.16 degrees.
// Depends on tcf_pkg for widths, the arctangent table and the status struct.
module tcf_cordic
#(
    parameter int STEPS = tcf_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [tcf_pkg::DATA_W-1:0]   x_in,
    input  logic signed [tcf_pkg::DATA_W-1:0]   y_in,
    output tcf_pkg::cordic_stat_t               stat,
    output logic signed [tcf_pkg::DATA_W-1:0]   x_out,
    output logic signed [tcf_pkg::ANGLE_W-1:0]  z_out
);
    import tcf_pkg::*;

    localparam int NSTEP = (STEPS > ATAN_LEN) ? ATAN_LEN : STEPS;
    localparam logic [STEP_W-1:0] LAST = STEP_W'(NSTEP - 1);

    logic signed [DATA_W-1:0]  x_reg, x_next;
    logic signed [DATA_W-1:0]  y_reg, y_next;
    logic signed [ANGLE_W-1:0] z_reg, z_next;
    logic [STEP_W-1:0]         cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    logic signed [DATA_W-1:0]  dx;
    logic signed [DATA_W-1:0]  dy;
    logic signed [ANGLE_W-1:0] dz;

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign dz = atan_deg(cnt_reg);

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = x_in;
            y_next    = y_in;
            z_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!y_reg[DATA_W-1] && (y_reg != '0))
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + dz;
            end
            else if (y_reg[DATA_W-1])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - dz;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign x_out     = x_reg;
    assign z_out     = z_reg;

endmodule

// ----- rtl/core/tilt_complementary_filter.sv -----
// Top level of the tilt complementary filter: sequencer, angle state and ports.
// Depends on tcf_pkg, tcf_cordic, tcf_mul and assert_macros.svh.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   s_*      | in        | s_tvalid/s_tready  | six 16-bit IMU samples
//   m_*      | out       | m_tvalid/m_tready  | roll, pitch, yaw Q16.16 degrees
//   cfg_*    | in        | cfg_valid/cfg_ready| register index and write data
//
// Each item makes four passes through the single CORDIC unit, one for the
// magnitude and one for the angle, for roll and again for pitch.
// s_tready is high only while the sequencer is idle; the result sits in an output
// register, so the next item is taken while it waits on m_tready.
// Reset clears the angle accumulators to zero and loads the register defaults.
`include "assert_macros.svh"

module tilt_complementary_filter
#(
    parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z (16 bits each, lowest first)
    input  logic [tcf_pkg::ITEM_W-1:0]        s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // roll_deg, pitch_deg, yaw_deg (32 bits each, lowest first)
    output logic [tcf_pkg::RESULT_W-1:0]      m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcf_pkg::WEIGHT_W-1:0]      cfg_data
);
    import tcf_pkg::*;

    state_t state_reg, state_next;

    logic                      axis_reg, axis_next;
    logic signed [SAMPLE_W-1:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic signed [ANGLE_W-1:0] roll_reg, roll_next;
    logic signed [ANGLE_W-1:0] pitch_reg, pitch_next;
    logic signed [ANGLE_W-1:0] yaw_reg, yaw_next;
    logic signed [ANGLE_W-1:0] ang_reg;
    logic signed [PROD_W-1:0]  sum_reg;
    logic [WEIGHT_W-1:0]       blend_reg;
    logic [SCALE_W-1:0]        scale_reg;
    logic [RESULT_W-1:0]       out_reg;
    logic                      m_tvalid_reg, m_tvalid_next;

    logic                      accept;
    logic                      out_load;
    logic                      cordic_start;
    logic signed [DATA_W-1:0]  cordic_x, cordic_y;
    cordic_stat_t              cordic_stat;
    logic signed [DATA_W-1:0]  cordic_xo;
    logic signed [ANGLE_W-1:0] cordic_zo;
    logic signed [DATA_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic signed [SAMPLE_W-1:0] cur_a, cur_num, cur_g;
    logic signed [ANGLE_W-1:0]  cur_acc;
    logic signed [DATA_W-1:0]   a_ext, a_abs;
    logic signed [PROD_W-1:0]   rate_sum, yaw_sum, blend_tot;
    logic [WEIGHT_W-1:0]        w_clamp, w_rest;

    tcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (cordic_x),
        .y_in  (cordic_y),
        .stat  (cordic_stat),
        .x_out (cordic_xo),
        .z_out (cordic_zo)
    );

    tcf_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign cur_a   = axis_reg ? ay_reg : ax_reg;
    assign cur_num = axis_reg ? ax_reg : ay_reg;
    assign cur_g   = axis_reg ? gy_reg : gx_reg;
    assign cur_acc = axis_reg ? pitch_reg : roll_reg;
    assign a_ext   = DATA_W'(cur_a);
    assign a_abs   = a_ext[DATA_W-1] ? -a_ext : a_ext;

    assign w_clamp = (blend_reg > ONE_Q16) ? ONE_Q16 : blend_reg;
    assign w_rest  = ONE_Q16 - w_clamp;

    assign rate_sum  = axis_reg ? (PROD_W'(cur_acc) + prod) : (PROD_W'(cur_acc) - prod);
    assign yaw_sum   = PROD_W'(yaw_reg) - prod;
    assign blend_tot = (sum_reg + prod) >>> FRAC_W;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_YAW_MUL;
            ST_YAW_MUL:   state_next = ST_YAW_ACC;
            ST_YAW_ACC:   state_next = ST_MAG;
            ST_MAG:       state_next = ST_MAG_WAIT;
            ST_MAG_WAIT:  if (cordic_stat.done) state_next = ST_GAIN;
            ST_GAIN:      state_next = ST_ANG_WAIT;
            ST_ANG_WAIT:  if (cordic_stat.done) state_next = ST_RATE;
            ST_RATE:      state_next = ST_BLEND_W;
            ST_BLEND_W:   state_next = ST_BLEND_A;
            ST_BLEND_A:   state_next = ST_BLEND_SUM;
            ST_BLEND_SUM: state_next = axis_reg ? ST_DONE : ST_MAG;
            ST_DONE:      if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready     = 1'b0;
        cordic_start = 1'b0;
        cordic_x     = a_abs <<< FRAC_W;
        cordic_y     = DATA_W'(az_reg) <<< FRAC_W;
        mul_a        = '0;
        mul_b        = '0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_YAW_MUL:
            begin
                mul_a = DATA_W'(gz_reg);
                mul_b = MUL_B_W'(scale_reg);
            end
            ST_MAG:
            begin
                cordic_start = 1'b1;
            end
            ST_MAG_WAIT:
            begin
                mul_a = cordic_xo;
                mul_b = INV_GAIN;
            end
            ST_GAIN:
            begin
                cordic_start = 1'b1;
                cordic_x     = prod[FRAC_W +: DATA_W];
                cordic_y     = DATA_W'(cur_num) <<< FRAC_W;
            end
            ST_ANG_WAIT:
            begin
                mul_a = DATA_W'(cur_g);
                mul_b = MUL_B_W'(scale_reg);
            end
            ST_BLEND_W:
            begin
                mul_a = DATA_W'(cur_acc);
                mul_b = MUL_B_W'(w_clamp);
            end
            ST_BLEND_A:
            begin
                mul_a = DATA_W'(ang_reg);
                mul_b = MUL_B_W'(w_rest);
            end
            ST_DONE:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        axis_next  = axis_reg;
        roll_next  = roll_reg;
        pitch_next = pitch_reg;
        yaw_next   = yaw_reg;
        if (accept)
        begin
            axis_next = 1'b0;
        end
        if (state_reg == ST_YAW_ACC)
        begin
            yaw_next = sat32(yaw_sum);
        end
        if (state_reg == ST_RATE)
        begin
            if (axis_reg)
            begin
                pitch_next = sat32(rate_sum);
            end
            else
            begin
                roll_next = sat32(rate_sum);
            end
        end
        if (state_reg == ST_BLEND_SUM)
        begin
            axis_next = 1'b1;
            if (axis_reg)
            begin
                pitch_next = sat32(blend_tot);
            end
            else
            begin
                roll_next = sat32(blend_tot);
            end
        end
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            axis_reg     <= 1'b0;
            roll_reg     <= '0;
            pitch_reg    <= '0;
            yaw_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            blend_reg    <= BLEND_RESET;
            scale_reg    <= SCALE_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            axis_reg     <= axis_next;
            roll_reg     <= roll_next;
            pitch_reg    <= pitch_next;
            yaw_reg      <= yaw_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && (cfg_index == REG_BLEND_WEIGHT))
            begin
                blend_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == REG_GYRO_SCALE))
            begin
                scale_reg <= cfg_data[SCALE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_reg <= s_tdata[0*SAMPLE_W +: SAMPLE_W];
            ay_reg <= s_tdata[1*SAMPLE_W +: SAMPLE_W];
            az_reg <= s_tdata[2*SAMPLE_W +: SAMPLE_W];
            gx_reg <= s_tdata[3*SAMPLE_W +: SAMPLE_W];
            gy_reg <= s_tdata[4*SAMPLE_W +: SAMPLE_W];
            gz_reg <= s_tdata[5*SAMPLE_W +: SAMPLE_W];
        end
        if ((state_reg == ST_ANG_WAIT) && cordic_stat.done)
        begin
            ang_reg <= cordic_zo;
        end
        if (state_reg == ST_BLEND_A)
        begin
            sum_reg <= prod;
        end
        if (out_load)
        begin
            out_reg <= {yaw_reg, pitch_reg, roll_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    `ASSERT_IMPLY(a_start_free, clk, rst_n, cordic_start, !cordic_stat.busy, "CORDIC restarted while busy")
    `ASSERT_IMPLY(a_done_waited, clk, rst_n, cordic_stat.done, (state_reg == ST_MAG_WAIT) || (state_reg == ST_ANG_WAIT), "CORDIC finished outside a wait state")
    `ASSERT_NEXT(a_out_load, clk, rst_n, out_load, m_tvalid && (state_reg == ST_IDLE), "result load did not raise m_tvalid")

endmodule

// ----- sim/tb_tilt_complementary_filter.sv -----
// Self-checking testbench for tilt_complementary_filter: directed table, then random phases.
// Predicts roll, pitch and yaw per IMU item from its own CORDIC and blend model.
// Depends on tcf_pkg and the filter RTL only.
module tb_tilt_complementary_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import tcf_pkg::*;

    localparam int     PRED_STEPS    = (CORDIC_STEPS_DEF > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS_DEF;
    localparam int     ITEM_CYCLES   = 4 * CORDIC_STEPS_DEF + 20;
    localparam int     ITEMS_TOTAL   = 1350;
    localparam int     CYCLE_LIMIT   = 1000000;
    localparam int     ACCEL_SPAN    = 16384;
    localparam int     RATE_SPAN     = 400;
    localparam longint ANGLE_MAX     = 64'sd2147483647;
    localparam longint ANGLE_MIN     = -ANGLE_MAX - 1;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] rate_x;
        logic signed [SAMPLE_W-1:0] rate_y;
        logic signed [SAMPLE_W-1:0] rate_z;
    } sample_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] yaw;
    } angles_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [WEIGHT_W-1:0]   reg_data;
        sample_t               smp;
        logic                  has_want;
        angles_t               want;
    } stim_row_t;

    localparam int NUM_DIRECTED = 27;

    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{ROW_SAMPLE, '0, '0, '{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0}},
        '{ROW_SAMPLE, '0, '0, '{0, 0, 0, 0, 0, 1}, 1'b1, '{0, 0, -1638}},
        '{ROW_SAMPLE, '0, '0, '{0, 0, 0, 0, 0, -1}, 1'b1, '{0, 0, 0}},
        '{ROW_WRITE, REG_BLEND_WEIGHT, 17'h10000, '0, 1'b0, '0},
        '{ROW_WRITE, REG_GYRO_SCALE, 17'h0FFFF, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{0, 0, 0, -32768, 0, 0}, 1'b1, '{2147450880, 0, 0}},
        '{ROW_SAMPLE, '0, '0, '{0, 0, 0, -32768, -32768, 32767}, 1'b1,
            '{32'sh7FFF_FFFF, -2147450880, -2147385345}},
        '{ROW_SAMPLE, '0, '0, '{0, 0, 0, 0, -32768, 32767}, 1'b1,
            '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000}},
        '{ROW_WRITE, REG_BLEND_WEIGHT, 17'h1FFFF, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{0, 0, 0, 32767, 0, 0}, 1'b1,
            '{98302, 32'sh8000_0000, 32'sh8000_0000}},
        '{ROW_WRITE, REG_BLEND_WEIGHT, 17'h00000, '0, 1'b0, '0},
        '{ROW_WRITE, REG_GYRO_SCALE, 17'h10000, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{0, 0, 0, 32767, 32767, 32767}, 1'b1, '{0, 0, 32'sh8000_0000}},
        '{ROW_SAMPLE, '0, '0, '{-32768, 32767, 0, 0, 0, 0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{32767, -32768, -32768, 0, 0, 0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{0, 0, 32767, 0, 0, 0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{0, -32768, 0, 0, 0, 0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{1, -1, 0, 0, 0, 0}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{-32768, -32768, -32768, -32768, -32768, -32768}, 1'b0, '0},
        '{ROW_WRITE, REG_UNUSED_HI, 17'h1FFFF, '0, 1'b0, '0},
        '{ROW_WRITE, REG_UNUSED_LO, 17'h00000, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{100, -200, 16384, 0, 0, 0}, 1'b0, '0},
        '{ROW_WRITE, REG_BLEND_WEIGHT, BLEND_RESET, '0, 1'b0, '0},
        '{ROW_WRITE, REG_GYRO_SCALE, SCALE_RESET, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{1000, -3000, 15000, 120, -50, 7}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{32767, 32767, 32767, 32767, 32767, 32767}, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, '{-1, -1, -1, -1, -1, -1}, 1'b0, '0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [ITEM_W-1:0]      s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [RESULT_W-1:0]    m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [WEIGHT_W-1:0]    cfg_data;

    logic signed [ANGLE_W-1:0] roll_st  = '0;
    logic signed [ANGLE_W-1:0] pitch_st = '0;
    logic signed [ANGLE_W-1:0] yaw_st   = '0;
    logic [WEIGHT_W-1:0]       weight_reg = BLEND_RESET;
    logic [SCALE_W-1:0]        scale_reg  = SCALE_RESET;

    angles_t attitude_q [$];
    int      item_cnt  = 0;
    int      fail_cnt  = 0;
    int      cycle_cnt = 0;
    bit      no_idle   = 1'b0;

    tilt_complementary_filter i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic signed [ANGLE_W-1:0] clamp32(input longint v);
        if (v > ANGLE_MAX)
        begin
            return ANGLE_MAX[ANGLE_W-1:0];
        end
        if (v < ANGLE_MIN)
        begin
            return ANGLE_MIN[ANGLE_W-1:0];
        end
        return v[ANGLE_W-1:0];
    endfunction

    function automatic longint vector_rotate(input longint x_in, input longint y_in,
                                             output longint x_out);
        longint x;
        longint y;
        longint z;
        longint x_prev;
        x = x_in;
        y = y_in;
        z = 0;
        for (int i = 0; i < PRED_STEPS; i++)
        begin
            x_prev = x;
            if (y > 0)
            begin
                x = x + (y >>> i);
                y = y - (x_prev >>> i);
                z = z + longint'(ATAN_DEG[i]);
            end
            else if (y < 0)
            begin
                x = x - (y >>> i);
                y = y + (x_prev >>> i);
                z = z - longint'(ATAN_DEG[i]);
            end
        end
        x_out = x;
        return z;
    endfunction

    function automatic longint tilt_deg(input longint num, input longint a, input longint b);
        longint mag;
        longint spare;
        if (a < 0)
        begin
            a = -a;
        end
        spare = vector_rotate(a * 65536, b * 65536, mag);
        mag = (mag * longint'(INV_GAIN)) >>> FRAC_W;
        return vector_rotate(mag, num * 65536, spare);
    endfunction

    function automatic logic signed [ANGLE_W-1:0] blend_angle(
        input logic signed [ANGLE_W-1:0] gyro_deg, input longint accel_deg);
        longint w;
        longint sum;
        w = (weight_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(weight_reg);
        sum = longint'(gyro_deg) * w + accel_deg * (longint'(ONE_Q16) - w);
        return clamp32(sum >>> FRAC_W);
    endfunction

    function automatic angles_t advance_attitude(input sample_t smp);
        longint                    scale;
        longint                    roll_accel;
        longint                    pitch_accel;
        logic signed [ANGLE_W-1:0] roll_gyro;
        logic signed [ANGLE_W-1:0] pitch_gyro;
        angles_t                   res;
        scale = longint'(scale_reg);
        roll_accel = tilt_deg($signed(smp.accel_y), $signed(smp.accel_x), $signed(smp.accel_z));
        pitch_accel = tilt_deg($signed(smp.accel_x), $signed(smp.accel_y), $signed(smp.accel_z));
        roll_gyro = clamp32(longint'(roll_st) - longint'($signed(smp.rate_x)) * scale);
        pitch_gyro = clamp32(longint'(pitch_st) + longint'($signed(smp.rate_y)) * scale);
        yaw_st = clamp32(longint'(yaw_st) - longint'($signed(smp.rate_z)) * scale);
        roll_st = blend_angle(roll_gyro, roll_accel);
        pitch_st = blend_angle(pitch_gyro, pitch_accel);
        res.roll = roll_st;
        res.pitch = pitch_st;
        res.yaw = yaw_st;
        return res;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_axis(input int span);
        case ($urandom_range(0, 15))
            0: return SAMPLE_W'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return -16'sd1;
                    2: return 16'sd0;
                    3: return 16'sd1;
                    default: return 16'sh7FFF;
                endcase
            end
            default: return SAMPLE_W'(int'($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    task automatic compare_angle(input string field, input logic signed [ANGLE_W-1:0] want_v,
                                 input logic signed [ANGLE_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
            fail_cnt++;
        end
    endtask

    task automatic push_sample(input sample_t smp, input logic has_want, input angles_t want);
        int      gap;
        angles_t pred;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while (!s_tready);
            repeat (gap - 1) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {smp.rate_z, smp.rate_y, smp.rate_x, smp.accel_z, smp.accel_y, smp.accel_x};
        do @(posedge clk); while (!(s_tvalid && s_tready));
        pred = advance_attitude(smp);
        attitude_q.push_back(has_want ? want : pred);
        item_cnt++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_BLEND_WEIGHT: weight_reg = value;
            REG_GYRO_SCALE:   scale_reg = value[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (attitude_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                do @(posedge clk); while (!m_tvalid);
                repeat (stall - 1) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge clk)
    begin
        angles_t got;
        angles_t want;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.roll  = m_tdata[ANGLE_W-1:0];
            got.pitch = m_tdata[2*ANGLE_W-1:ANGLE_W];
            got.yaw   = m_tdata[3*ANGLE_W-1:2*ANGLE_W];
            if (attitude_q.size() == 0)
            begin
                $error("result with no item pending: roll_deg %0d pitch_deg %0d yaw_deg %0d",
                       got.roll, got.pitch, got.yaw);
                fail_cnt++;
            end
            else
            begin
                want = attitude_q.pop_front();
                compare_angle("roll_deg", want.roll, got.roll);
                compare_angle("pitch_deg", want.pitch, got.pitch);
                compare_angle("yaw_deg", want.yaw, got.yaw);
            end
        end
    end

    initial
    begin
        sample_t             smp;
        int                  phase_len;
        logic [WEIGHT_W-1:0] weight_data;
        logic [WEIGHT_W-1:0] scale_data;
        bit                  cfg_open;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        cfg_open  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == ROW_WRITE)
            begin
                if (!cfg_open)
                begin
                    settle();
                    cfg_open = 1'b1;
                end
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_data);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                push_sample(DIRECTED[i].smp, DIRECTED[i].has_want, DIRECTED[i].want);
            end
        end

        while (item_cnt < ITEMS_TOTAL)
        begin
            settle();
            case ($urandom_range(0, 5))
                0: weight_data = '0;
                1: weight_data = ONE_Q16;
                2: weight_data = WEIGHT_W'($urandom_range(ONE_Q16 + 1, 2**WEIGHT_W - 1));
                default: weight_data = WEIGHT_W'($urandom_range(0, ONE_Q16));
            endcase
            case ($urandom_range(0, 4))
                0: scale_data = '0;
                1: scale_data = {1'($urandom_range(0, 1)), 16'hFFFF};
                2: scale_data = WEIGHT_W'($urandom_range(0, 2**WEIGHT_W - 1));
                default: scale_data = WEIGHT_W'($urandom_range(0, 4096));
            endcase
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                          WEIGHT_W'($urandom_range(0, 2**WEIGHT_W - 1)));
            end
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_BLEND_WEIGHT, weight_data);
                write_reg(REG_GYRO_SCALE, scale_data);
            end
            else
            begin
                write_reg(REG_GYRO_SCALE, scale_data);
                write_reg(REG_BLEND_WEIGHT, weight_data);
            end
            cfg_valid <= 1'b0;
            no_idle = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 200);
            repeat (phase_len)
            begin
                smp.accel_x = draw_axis(ACCEL_SPAN);
                smp.accel_y = draw_axis(ACCEL_SPAN);
                smp.accel_z = draw_axis(ACCEL_SPAN);
                smp.rate_x  = draw_axis(RATE_SPAN);
                smp.rate_y  = draw_axis(RATE_SPAN);
                smp.rate_z  = draw_axis(RATE_SPAN);
                if ($urandom_range(0, 31) == 0)
                begin
                    smp.accel_x = '0;
                    smp.accel_y = '0;
                    smp.accel_z = '0;
                end
                push_sample(smp, 1'b0, '0);
            end
        end

        no_idle = 1'b0;
        settle();
        repeat (2 * ITEM_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && attitude_q.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
